[hw/rtl/assert_macros.svh]
// Assertion helpers; every check is clocked and masked while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds, so the consequent must hold in the same cycle.
`define WSUV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent holds, so the consequent must hold in the next cycle.
`define WSUV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wsuv_pkg.sv]
`timescale 1ns / 1ps

package wsuv_pkg;

    localparam int unsigned LIMIT_W = 11;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd512;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP   = 11'd1024;
    localparam logic [LIMIT_W-1:0] COUNT_SAT   = 11'd1025;

    localparam logic [3:0] PATH_LEN = 4'd13;

    // Result item as it leaves the parser.
    typedef struct packed {
        logic        url_valid;
        logic        secure_scheme;
        logic        port_given;
        logic [15:0] port_number;
    } t_verdict;

    // Expected path text "/v1/device/ws", one character per index.
    function automatic logic [7:0] path_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h2f; // '/'
            4'd1:    c = 8'h76; // 'v'
            4'd2:    c = 8'h31; // '1'
            4'd3:    c = 8'h2f; // '/'
            4'd4:    c = 8'h64; // 'd'
            4'd5:    c = 8'h65; // 'e'
            4'd6:    c = 8'h76; // 'v'
            4'd7:    c = 8'h69; // 'i'
            4'd8:    c = 8'h63; // 'c'
            4'd9:    c = 8'h65; // 'e'
            4'd10:   c = 8'h2f; // '/'
            4'd11:   c = 8'h77; // 'w'
            4'd12:   c = 8'h73; // 's'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/websocket_url_validator_top.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// WebSocket endpoint URL checker. Bytes of a URL enter on the slave stream, one per
// cycle while o_s_tready is high, with tlast on the final byte. Each byte goes through
// an input register and one pass of the grammar logic, and the verdict for a URL is
// registered in the result register when its last byte leaves the input register.
// Non-final bytes give no output. A stall on the master side holds only a URL end
// that finds the result register still full. The length limit is written through
// the configuration port (reset 512, values above 1024 act as 1024) and must only
// change between URLs.
module websocket_url_validator_top import wsuv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,  // [7:0] url_byte
    input  logic               i_s_tlast,  // last_byte
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // [0] url_valid, [1] secure_scheme, [2] port_given, [18:3] port_number, [23:19] zero
    output logic [23:0]        o_m_tdata
);

    logic [LIMIT_W-1:0] r_limit;
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               r_out_valid;
    t_verdict           r_out_data;

    logic               w_advance;
    logic [LIMIT_W-1:0] w_limit;
    t_verdict           w_verdict;

    assign w_limit   = (r_limit > LIMIT_CAP) ? LIMIT_CAP : r_limit;
    // A final byte needs room in the result register; others always move on.
    assign w_advance = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    wsuv_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_limit   (w_limit),
        .o_verdict (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out_data <= w_verdict;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_data.port_number, r_out_data.port_given,
                         r_out_data.secure_scheme, r_out_data.url_valid};

    `WSUV_ASSERT_SAME(a_reject_fields_zero, i_clk, i_rst_n, r_out_valid && !r_out_data.url_valid, !r_out_data.secure_scheme && !r_out_data.port_given && r_out_data.port_number == 16'd0, "rejected verdict carries nonzero fields")
    `WSUV_ASSERT_SAME(a_port_nonzero, i_clk, i_rst_n, r_out_valid && r_out_data.port_given, r_out_data.port_number != 16'd0 && r_out_data.url_valid, "given port is zero or verdict invalid")
    `WSUV_ASSERT_NEXT(a_last_waits, i_clk, i_rst_n, r_in_valid && r_in_last && r_out_valid && !i_m_tready, r_in_valid && r_in_last && r_out_valid, "final byte lost while result stalled")

endmodule

[hw/rtl/wsuv_parser.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wsuv_parser import wsuv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_verdict           o_verdict
);

    localparam logic [3:0] PH_W1    = 4'd0;
    localparam logic [3:0] PH_S1    = 4'd1;
    localparam logic [3:0] PH_S2    = 4'd2;
    localparam logic [3:0] PH_COLON = 4'd3;
    localparam logic [3:0] PH_SL1   = 4'd4;
    localparam logic [3:0] PH_SL2   = 4'd5;
    localparam logic [3:0] PH_HOST  = 4'd6;
    localparam logic [3:0] PH_PORT  = 4'd7;
    localparam logic [3:0] PH_PATH  = 4'd8;

    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_QUEST = 8'h3f;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_RBRK  = 8'h5d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [19:0] PORT_MAX = 20'd65535;

    logic [3:0]         r_phase;
    logic [LIMIT_W-1:0] r_count;
    logic [16:0]        r_port_acc;
    logic               r_host_seen;
    logic               r_digit_seen;
    logic [3:0]         r_path_idx;
    logic               r_rejected;
    logic               r_wss;

    logic [3:0]         n_phase;
    logic [LIMIT_W-1:0] n_count;
    logic [16:0]        n_port_acc;
    logic               n_host_seen;
    logic               n_digit_seen;
    logic [3:0]         n_path_idx;
    logic               n_rejected;
    logic               n_wss;

    // State after this byte, before the end-of-URL clear.
    logic [3:0]         p_phase;
    logic [LIMIT_W-1:0] p_count;
    logic [16:0]        p_port_acc;
    logic               p_host_seen;
    logic               p_digit_seen;
    logic [3:0]         p_path_idx;
    logic               p_rejected;
    logic               p_wss;

    logic [19:0] port_next;
    logic        is_digit;
    logic        host_ok;
    logic        ok;

    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    // acc * 10 + digit
    assign port_next = ({3'b000, r_port_acc} << 3) + ({3'b000, r_port_acc} << 1)
                     + {12'd0, i_byte - CH_ZERO};
    assign host_ok   = (i_byte > CH_SPACE) && (i_byte < CH_DEL)
                     && (i_byte != CH_SLASH) && (i_byte != CH_BSL) && (i_byte != CH_AT)
                     && (i_byte != CH_QUEST) && (i_byte != CH_HASH)
                     && (i_byte != CH_LBRK) && (i_byte != CH_RBRK);

    always_comb begin
        p_phase      = r_phase;
        p_count      = r_count;
        p_port_acc   = r_port_acc;
        p_host_seen  = r_host_seen;
        p_digit_seen = r_digit_seen;
        p_path_idx   = r_path_idx;
        p_rejected   = r_rejected;
        p_wss        = r_wss;

        if (r_count < COUNT_SAT) begin
            p_count = r_count + 11'd1;
        end

        if (!r_rejected) begin
            unique case (r_phase)
                PH_W1: begin
                    if (i_byte == CH_W) p_phase = PH_S1;
                    else p_rejected = 1'b1;
                end
                PH_S1: begin
                    if (i_byte == CH_S) p_phase = PH_S2;
                    else p_rejected = 1'b1;
                end
                PH_S2: begin
                    if (i_byte == CH_COLON) begin
                        p_phase = PH_SL1;
                    end else if (i_byte == CH_S) begin
                        p_wss   = 1'b1;
                        p_phase = PH_COLON;
                    end else begin
                        p_rejected = 1'b1;
                    end
                end
                PH_COLON: begin
                    if (i_byte == CH_COLON) p_phase = PH_SL1;
                    else p_rejected = 1'b1;
                end
                PH_SL1: begin
                    if (i_byte == CH_SLASH) p_phase = PH_SL2;
                    else p_rejected = 1'b1;
                end
                PH_SL2: begin
                    if (i_byte == CH_SLASH) p_phase = PH_HOST;
                    else p_rejected = 1'b1;
                end
                PH_HOST: begin
                    if (i_byte == CH_COLON || i_byte == CH_SLASH) begin
                        if (!r_host_seen) begin
                            p_rejected = 1'b1;
                        end else if (i_byte == CH_COLON) begin
                            p_phase = PH_PORT;
                        end else begin
                            p_phase    = PH_PATH;
                            p_path_idx = 4'd1;
                        end
                    end else if (host_ok) begin
                        p_host_seen = 1'b1;
                    end else begin
                        p_rejected = 1'b1;
                    end
                end
                PH_PORT: begin
                    if (is_digit) begin
                        if (port_next > PORT_MAX) begin
                            p_rejected = 1'b1;
                        end else begin
                            p_port_acc   = port_next[16:0];
                            p_digit_seen = 1'b1;
                        end
                    end else if (i_byte == CH_SLASH && r_digit_seen && r_port_acc != 17'd0) begin
                        p_phase    = PH_PATH;
                        p_path_idx = 4'd1;
                    end else begin
                        p_rejected = 1'b1;
                    end
                end
                PH_PATH: begin
                    if (r_path_idx < PATH_LEN && i_byte == path_char(r_path_idx)) begin
                        p_path_idx = r_path_idx + 4'd1;
                    end else begin
                        p_rejected = 1'b1;
                    end
                end
                default: p_rejected = 1'b1;
            endcase
        end

        ok = !p_rejected && (p_phase == PH_PATH) && (p_path_idx == PATH_LEN)
           && (p_count <= i_limit);
        o_verdict.url_valid     = ok;
        o_verdict.secure_scheme = ok && p_wss;
        o_verdict.port_given    = ok && p_digit_seen;
        o_verdict.port_number   = (ok && p_digit_seen) ? p_port_acc[15:0] : 16'd0;

        if (i_last) begin
            n_phase      = PH_W1;
            n_count      = '0;
            n_port_acc   = '0;
            n_host_seen  = 1'b0;
            n_digit_seen = 1'b0;
            n_path_idx   = '0;
            n_rejected   = 1'b0;
            n_wss        = 1'b0;
        end else begin
            n_phase      = p_phase;
            n_count      = p_count;
            n_port_acc   = p_port_acc;
            n_host_seen  = p_host_seen;
            n_digit_seen = p_digit_seen;
            n_path_idx   = p_path_idx;
            n_rejected   = p_rejected;
            n_wss        = p_wss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_W1;
            r_count      <= '0;
            r_port_acc   <= '0;
            r_host_seen  <= 1'b0;
            r_digit_seen <= 1'b0;
            r_path_idx   <= '0;
            r_rejected   <= 1'b0;
            r_wss        <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_count      <= n_count;
            r_port_acc   <= n_port_acc;
            r_host_seen  <= n_host_seen;
            r_digit_seen <= n_digit_seen;
            r_path_idx   <= n_path_idx;
            r_rejected   <= n_rejected;
            r_wss        <= n_wss;
        end
    end

    `WSUV_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, i_step && i_last, r_phase == PH_W1 && r_count == '0 && !r_rejected, "parse state not cleared after last byte")
    `WSUV_ASSERT_SAME(a_port_in_range, i_clk, i_rst_n, r_digit_seen, r_port_acc <= 17'd65535 && r_phase == PH_PORT || r_phase == PH_PATH || r_rejected, "port accumulator out of range or phase mismatch")

endmodule

[bench/url_verdict_checker.sv]
`timescale 1ns / 1ps

module url_verdict_checker import wsuv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [7:0]         i_s_tdata,  // [7:0] url_byte
    input  logic               i_s_tlast,  // last_byte
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    // [0] url_valid, [1] secure_scheme, [2] port_given, [18:3] port_number, [23:19] zero
    input  logic [23:0]        i_m_tdata,
    output int unsigned        o_fail_count,
    output int unsigned        o_pending
);

    typedef enum logic [3:0] {
        SCHEME_W,
        SCHEME_S1,
        SCHEME_S2,
        SCHEME_COLON,
        SLASH_1,
        SLASH_2,
        IN_HOST,
        IN_PORT,
        IN_PATH
    } t_url_phase;

    localparam logic [8*13-1:0] ENDPOINT_PATH = "/v1/device/ws";
    localparam logic [7:0] CH_W        = "w";
    localparam logic [7:0] CH_S        = "s";
    localparam logic [7:0] CH_COLON    = ":";
    localparam logic [7:0] CH_SLASH    = "/";
    localparam logic [7:0] CH_0        = "0";
    localparam logic [7:0] CH_9        = "9";
    localparam logic [7:0] PRINT_FLOOR = 8'h20;
    localparam logic [7:0] PRINT_CEIL  = 8'h7f;
    localparam int unsigned PORT_MAX   = 65535;

    logic [LIMIT_W-1:0] url_limit  = LIMIT_RESET;
    t_url_phase         phase      = SCHEME_W;
    logic [10:0]        byte_count = '0;
    logic [16:0]        port_acc   = '0;
    logic               host_seen  = 1'b0;
    logic               digit_seen = 1'b0;
    logic               rejected   = 1'b0;
    logic               wss_seen   = 1'b0;
    logic [3:0]         path_idx   = '0;
    t_verdict           verdict_q[$];
    int unsigned        mismatches = 0;

    task automatic clear_parse();
        phase      = SCHEME_W;
        byte_count = '0;
        port_acc   = '0;
        host_seen  = 1'b0;
        digit_seen = 1'b0;
        rejected   = 1'b0;
        wss_seen   = 1'b0;
        path_idx   = '0;
    endtask

    function automatic logic host_byte_legal(input logic [7:0] c);
        return c > PRINT_FLOOR && c < PRINT_CEIL
            && !(c inside {"/", "\\", "@", "?", "#", "[", "]"});
    endfunction

    task automatic parse_url_byte(input logic [7:0] c);
        int unsigned port_next;
        case (phase)
            SCHEME_W: begin
                if (c == CH_W) phase = SCHEME_S1; else rejected = 1'b1;
            end
            SCHEME_S1: begin
                if (c == CH_S) phase = SCHEME_S2; else rejected = 1'b1;
            end
            SCHEME_S2: begin
                if (c == CH_COLON) begin
                    phase = SLASH_1;
                end else if (c == CH_S) begin
                    wss_seen = 1'b1;
                    phase = SCHEME_COLON;
                end else begin
                    rejected = 1'b1;
                end
            end
            SCHEME_COLON: begin
                if (c == CH_COLON) phase = SLASH_1; else rejected = 1'b1;
            end
            SLASH_1: begin
                if (c == CH_SLASH) phase = SLASH_2; else rejected = 1'b1;
            end
            SLASH_2: begin
                if (c == CH_SLASH) phase = IN_HOST; else rejected = 1'b1;
            end
            IN_HOST: begin
                if (c == CH_COLON || c == CH_SLASH) begin
                    if (!host_seen) begin
                        rejected = 1'b1;
                    end else if (c == CH_COLON) begin
                        phase = IN_PORT;
                    end else begin
                        phase = IN_PATH;
                        path_idx = 4'd1;
                    end
                end else if (host_byte_legal(c)) begin
                    host_seen = 1'b1;
                end else begin
                    rejected = 1'b1;
                end
            end
            IN_PORT: begin
                if (c >= CH_0 && c <= CH_9) begin
                    port_next = port_acc * 10 + (c - CH_0);
                    if (port_next > PORT_MAX) begin
                        rejected = 1'b1;
                    end else begin
                        port_acc = port_next[16:0];
                        digit_seen = 1'b1;
                    end
                end else if (c == CH_SLASH && digit_seen && port_acc != 0) begin
                    phase = IN_PATH;
                    path_idx = 4'd1;
                end else begin
                    rejected = 1'b1;
                end
            end
            IN_PATH: begin
                if (path_idx < PATH_LEN && c == ENDPOINT_PATH[8*(12-path_idx) +: 8])
                    path_idx++;
                else
                    rejected = 1'b1;
            end
            default: rejected = 1'b1;
        endcase
    endtask

    function automatic t_verdict judge_url();
        t_verdict v;
        logic [LIMIT_W-1:0] cap;
        logic ok;
        cap = (url_limit > LIMIT_CAP) ? LIMIT_CAP : url_limit;
        ok = !rejected && phase == IN_PATH && path_idx == PATH_LEN && byte_count <= cap;
        v.url_valid     = ok;
        v.secure_scheme = ok && wss_seen;
        v.port_given    = ok && digit_seen;
        v.port_number   = (ok && digit_seen) ? port_acc[15:0] : 16'd0;
        return v;
    endfunction

    task automatic report_mismatch(input string why, input t_verdict want,
                                   input logic [23:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected valid=%0b wss=%0b port_given=%0b port=%0d, got valid=%0b wss=%0b port_given=%0b port=%0d pad=%0h",
                     $realtime, why, want.url_valid, want.secure_scheme, want.port_given,
                     want.port_number, got[0], got[1], got[2], got[18:3], got[23:19]);
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict got;
        if (!i_rst_n) begin
            url_limit = LIMIT_RESET;
            clear_parse();
        end else begin
            if (i_cfg_wr_en) url_limit = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) begin
                if (byte_count < COUNT_SAT) byte_count++;
                if (!rejected) parse_url_byte(i_s_tdata);
                // A URL end yields one verdict and restarts the grammar.
                if (i_s_tlast) begin
                    verdict_q.push_back(judge_url());
                    clear_parse();
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.url_valid     = i_m_tdata[0];
                got.secure_scheme = i_m_tdata[1];
                got.port_given    = i_m_tdata[2];
                got.port_number   = i_m_tdata[18:3];
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with no URL pending", '0, i_m_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    if (want !== got || i_m_tdata[23:19] !== 5'd0)
                        report_mismatch("verdict mismatch", want, i_m_tdata);
                end
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= mismatches;
    end

endmodule

[bench/tb_websocket_url_validator_top.sv]
`timescale 1ns / 1ps

module tb_websocket_url_validator_top;
    import wsuv_pkg::*;

    localparam string ENDPOINT = "/v1/device/ws";

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wr_data = '0;
    logic               i_s_tvalid    = 1'b0;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata     = '0;
    logic               i_s_tlast     = 1'b0;
    logic               o_m_tvalid;
    logic               i_m_tready    = 1'b0;
    logic [23:0]        o_m_tdata;

    int unsigned fail_count;
    int unsigned pending;
    bit          quiet = 1'b0;
    logic [7:0]  url_bytes[$];
    int unsigned random_bytes = 0;

    websocket_url_validator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    url_verdict_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // Stall the verdict side now and then, except during a quiet phase.
    always @(posedge i_clk) begin
        i_m_tready <= quiet || ($urandom_range(99) >= 8);
    end

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) url_bytes.push_back(s[k]);
    endtask

    task automatic add_host(input int unsigned n);
        logic [7:0] c;
        repeat (n) begin
            do c = 8'($urandom_range(33, 126));
            while (c inside {"/", "\\", "@", "?", "#", "[", "]", ":"});
            url_bytes.push_back(c);
        end
    endtask

    task automatic add_port(input int unsigned value, input int unsigned zeros);
        add_text(":");
        repeat (zeros) add_text("0");
        add_text($sformatf("%0d", value));
    endtask

    function automatic string pick_scheme();
        return $urandom_range(1) ? "wss://" : "ws://";
    endfunction

    task automatic send_url();
        foreach (url_bytes[k]) begin
            while (!quiet && $urandom_range(99) < 8) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= url_bytes[k];
            i_s_tlast  <= (k == url_bytes.size() - 1);
            do @(posedge i_clk); while (!o_s_tready);
        end
        url_bytes.delete();
    endtask

    task automatic send_text(input string s);
        url_bytes.delete();
        add_text(s);
        send_url();
    endtask

    task automatic build_good_url();
        int unsigned port;
        url_bytes.delete();
        add_text(pick_scheme());
        add_host($urandom_range(1, 12));
        if ($urandom_range(1)) begin
            case ($urandom_range(3))
                0:       port = 1;
                1:       port = 65535;
                2:       port = $urandom_range(1, 65535);
                default: port = $urandom_range(1, 999);
            endcase
            add_port(port, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
        end
        add_text(ENDPOINT);
    endtask

    task automatic break_url();
        int unsigned cut;
        string       odd_chars;
        odd_chars = "\\@?#[] ";
        case ($urandom_range(8))
            0: begin
                build_good_url();
                url_bytes[$urandom_range(url_bytes.size() - 1)] = 8'($urandom_range(255));
            end
            1: begin
                // End the URL early.
                build_good_url();
                cut = $urandom_range(url_bytes.size() - 1);
                repeat (cut) void'(url_bytes.pop_back());
            end
            2: begin
                build_good_url();
                url_bytes.push_back(8'($urandom_range(255)));
            end
            3: begin
                url_bytes.delete();
                add_text(pick_scheme());
                add_host($urandom_range(1, 8));
                add_port($urandom_range(65536, 999999), $urandom_range(1));
                add_text(ENDPOINT);
            end
            4: begin
                url_bytes.delete();
                add_text(pick_scheme());
                add_host($urandom_range(1, 8));
                if ($urandom_range(1)) add_port(0, $urandom_range(2));
                else add_text(":");
                add_text(ENDPOINT);
            end
            5: begin
                url_bytes.delete();
                add_text(pick_scheme());
                add_host($urandom_range(1, 8));
                add_port($urandom_range(1, 999), 0);
                add_port($urandom_range(1, 999), 0);
                add_text(ENDPOINT);
            end
            6: begin
                url_bytes.delete();
                add_text(pick_scheme());
                if ($urandom_range(1)) add_port($urandom_range(1, 65535), 0);
                add_text(ENDPOINT);
            end
            7: begin
                url_bytes.delete();
                add_text(pick_scheme());
                add_host($urandom_range(4));
                case ($urandom_range(2))
                    0:       url_bytes.push_back(odd_chars[$urandom_range(odd_chars.len() - 1)]);
                    1:       url_bytes.push_back(8'($urandom_range(0, 32)));
                    default: url_bytes.push_back(8'($urandom_range(127, 255)));
                endcase
                add_host($urandom_range(4));
                add_text(ENDPOINT);
            end
            default: begin
                url_bytes.delete();
                repeat ($urandom_range(1, 30)) url_bytes.push_back(8'($urandom_range(255)));
            end
        endcase
    endtask

    // Hold the stream until every verdict is back, then let the pipeline settle.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int unsigned phase_no;
        logic [LIMIT_W-1:0] limit;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Grammar corners under the reset limit.
        send_text("ws://a/v1/device/ws");
        send_text("wss://example.net:443/v1/device/ws");
        send_text("ws://h:65535/v1/device/ws");
        send_text("wss://h:00001/v1/device/ws");
        send_text("ws://h:65536/v1/device/ws");
        send_text("ws://h:0/v1/device/ws");
        send_text("ws://h:/v1/device/ws");
        send_text("ws://:80/v1/device/ws");
        send_text("ws:///v1/device/ws");
        send_text("ws://h:1:2/v1/device/ws");
        send_text("ws://h:8a/v1/device/ws");
        send_text("ws://a b/v1/device/ws");
        send_text("ws://a\\b/v1/device/ws");
        send_text("ws://a\177/v1/device/ws");
        send_text("ws://user@h/v1/device/ws");
        send_text("wss://h/v1/device/wsx");
        send_text("ws://h/v1/device/w");
        send_text("wx://h/v1/device/ws");
        send_text("w");
        url_bytes.push_back(8'hff);
        send_url();

        // Length limit: exact fit, one short, zero, one.
        set_limit(11'd19);
        send_text("ws://a/v1/device/ws");
        set_limit(11'd18);
        send_text("ws://a/v1/device/ws");
        set_limit(11'd0);
        send_text("wss://a:1/v1/device/ws");
        set_limit(11'd1);
        send_text("w");

        // Longest URLs, and a limit above the cap.
        set_limit(11'd1024);
        url_bytes.delete();
        add_text("ws://");
        add_host(1006);
        add_text(ENDPOINT);
        send_url();
        set_limit(11'd2047);
        url_bytes.delete();
        add_text("ws://");
        add_host(1007);
        add_text(ENDPOINT);
        send_url();
        url_bytes.delete();
        add_text("wss://");
        add_host(1004);
        add_port(8080, 0);
        add_text(ENDPOINT);
        send_url();

        phase_no = 0;
        while (random_bytes < 550) begin
            quiet = (phase_no == 1);
            case ($urandom_range(3))
                0:       limit = LIMIT_RESET;
                1:       limit = $urandom_range(1) ? 11'd1024 : 11'd2047;
                2:       limit = 11'($urandom_range(15, 45));
                default: limit = 11'($urandom_range(0, 2047));
            endcase
            set_limit(limit);
            repeat (15) begin
                if ($urandom_range(9) < 7) build_good_url();
                else break_url();
                random_bytes += url_bytes.size();
                send_url();
                if ($urandom_range(19) == 0) drain();
            end
            phase_no++;
        end
        quiet = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
